### hw/rtl/signed_varint_codec_defines.svh
// Assertion macros for the signed varint codec checker.
// Expects clk and rst in the scope of each use.
`ifndef SIGNED_VARINT_CODEC_DEFINES_SVH
`define SIGNED_VARINT_CODEC_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SVC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svc check failed");

// Next-cycle implication, disabled in reset.
`define SVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svc check failed");

`endif

### hw/rtl/svc_pkg.sv
// Shared types and constants of the signed varint codec.
// No dependencies.
package svc_pkg;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] SIGN_MASK  = 8'h80;
  localparam logic [7:0] CONT_FIRST = 8'h40;
  localparam logic [7:0] MAG_FIRST  = 8'h3F;
  localparam logic [7:0] MAG_NEXT   = 8'h7F;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [2:0] POS_FIRST = 3'd0;
  localparam logic [2:0] POS_LAST  = 3'd4;

  typedef struct packed {
    logic signed [31:0] number_in;
    logic [7:0]         byte_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         byte_out;
    logic               last_byte;
    logic signed [31:0] number_out;
    logic               number_valid;
  } out_word_t;

  typedef struct packed {
    logic        dir;
    logic        sign;
    logic [2:0]  nbytes;
    logic [31:0] data;
  } cmd_t;

endpackage

### hw/rtl/signed_varint_codec.sv
// Signed varint codec top level: front end, command queue, back end.
// Depends on svc_pkg, svc_front, svc_fifo, svc_back.
//
// Encodes signed 32-bit numbers into one to five sign-magnitude varint bytes,
// or decodes such bytes back into numbers, as chosen by the direction register
// (write it only while the codec is idle; a write drops any partial number).
// Numbers and bytes are pushed into a four-deep command queue; results leave
// through a one-word output register. The back end byte emitter sends the one
// to five bytes of a number in turn, held while the result word is not popped.
// Decoding gives one result word per byte, with number_valid set on the byte
// that completes a number.
module signed_varint_codec (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  svc_pkg::in_word_t  item,
  output logic               empty,
  input  logic               pop,
  output svc_pkg::out_word_t result,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import svc_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t front_cmd;
  cmd_t back_cmd;

  svc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (front_cmd)
  );

  svc_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wdata   (front_cmd),
    .q_full  (q_full),
    .rd      (q_pop),
    .rdata   (back_cmd),
    .q_empty (q_empty)
  );

  svc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .q_empty (q_empty),
    .q_cmd   (back_cmd),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

### hw/rtl/svc_front.sv
// Front end: direction register, input acceptance and classification.
// Depends on svc_pkg.
module svc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  svc_pkg::in_word_t item,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             q_full,
  output logic             q_push,
  output svc_pkg::cmd_t    q_cmd
);
  import svc_pkg::*;

  logic        direction;
  logic [31:0] raw;
  logic [31:0] mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (cfg_we) begin
      direction <= cfg_wdata;
    end
  end

  assign full   = q_full;
  assign q_push = push && !q_full;
  assign raw    = item.number_in;
  assign mag    = raw[31] ? (32'd0 - raw) : raw;

  always_comb begin
    q_cmd     = '0;
    q_cmd.dir = direction;
    if (direction == DIR_DECODE) begin
      q_cmd.data = {24'd0, item.byte_in};
    end else begin
      q_cmd.data = mag;
      q_cmd.sign = raw[31] || (raw == 32'd0);
      if (mag[31:27] != '0) begin
        q_cmd.nbytes = 3'd5;
      end else if (mag[26:20] != '0) begin
        q_cmd.nbytes = 3'd4;
      end else if (mag[19:13] != '0) begin
        q_cmd.nbytes = 3'd3;
      end else if (mag[12:6] != '0) begin
        q_cmd.nbytes = 3'd2;
      end else begin
        q_cmd.nbytes = 3'd1;
      end
    end
  end

endmodule

### hw/rtl/svc_fifo.sv
// Short command queue between front and back end.
// Depends on svc_pkg.
module svc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  svc_pkg::cmd_t wdata,
  output logic          q_full,
  input  logic          rd,
  output svc_pkg::cmd_t rdata,
  output logic          q_empty
);
  import svc_pkg::*;

  cmd_t           slots [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;
  logic           do_wr;
  logic           do_rd;

  assign q_full  = (count == (QAW+1)'(QDEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/svc_back.sv
// Back end: byte emitter, decode accumulator and result register.
// Depends on svc_pkg.
module svc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               q_empty,
  input  svc_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output svc_pkg::out_word_t result
);
  import svc_pkg::*;

  logic        out_valid;
  out_word_t   out_reg;
  out_word_t   out_next;
  logic        busy;
  logic [2:0]  remain;
  logic [25:0] shreg;
  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [2:0]  pos;
  logic        neg;
  logic        neg_eff;
  logic        done;
  logic [7:0]  b;
  logic [31:0] grp;
  logic        load_ok;
  logic        more;

  assign load_ok = !out_valid || pop;
  assign q_pop   = load_ok && !busy && !q_empty;
  assign empty   = !out_valid;
  assign result  = out_reg;
  assign b       = q_cmd.data[7:0];
  assign more    = remain > 3'd1;

  always_comb begin
    grp = '0;
    case (pos)
      3'd1:    grp = {25'd0, b[6:0]} << 6;
      3'd2:    grp = {25'd0, b[6:0]} << 13;
      3'd3:    grp = {25'd0, b[6:0]} << 20;
      default: grp = {25'd0, b[6:0]} << 27;
    endcase
    if (pos == POS_FIRST) begin
      acc_next = {26'd0, b[5:0]};
      neg_eff  = b[7];
      done     = !b[6];
    end else begin
      acc_next = acc | grp;
      neg_eff  = neg;
      done     = !b[7] || (pos >= POS_LAST);
    end
  end

  always_comb begin
    out_next = '0;
    if (busy) begin
      out_next.byte_out  = (more ? SIGN_MASK : 8'd0) | ({2'd0, shreg[5:0]} & MAG_NEXT)
                           | {1'b0, shreg[6], 6'd0};
      out_next.last_byte = !more;
    end else if (q_cmd.dir == DIR_ENCODE) begin
      out_next.byte_out  = (q_cmd.sign ? SIGN_MASK : 8'd0)
                           | ((q_cmd.nbytes != 3'd1) ? CONT_FIRST : 8'd0)
                           | (q_cmd.data[7:0] & MAG_FIRST);
      out_next.last_byte = (q_cmd.nbytes == 3'd1);
    end else if (done) begin
      out_next.number_out   = neg_eff ? (32'd0 - acc_next) : acc_next;
      out_next.number_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && (busy || q_pop)) begin
      out_reg <= out_next;
    end
    if (busy && load_ok) begin
      shreg <= shreg >> 7;
    end else if (q_pop) begin
      shreg <= q_cmd.data[31:6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      remain    <= '0;
      acc       <= '0;
      pos       <= POS_FIRST;
      neg       <= 1'b0;
    end else begin
      if (load_ok) begin
        out_valid <= busy || q_pop;
      end
      if (busy && load_ok) begin
        remain <= remain - 1'b1;
        busy   <= more;
      end else if (q_pop && (q_cmd.dir == DIR_ENCODE)) begin
        remain <= q_cmd.nbytes - 1'b1;
        busy   <= (q_cmd.nbytes != 3'd1);
      end
      if (cfg_we) begin
        acc <= '0;
        pos <= POS_FIRST;
        neg <= 1'b0;
      end else if (q_pop && (q_cmd.dir == DIR_DECODE)) begin
        if (done) begin
          acc <= '0;
          pos <= POS_FIRST;
          neg <= 1'b0;
        end else begin
          acc <= acc_next;
          pos <= pos + 1'b1;
          neg <= neg_eff;
        end
      end
    end
  end

endmodule

### hw/rtl/svc_checker.sv
// Port-level checks for the signed varint codec, bound to the top level.
// Depends on svc_pkg and signed_varint_codec_defines.svh.
`include "signed_varint_codec_defines.svh"

module svc_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input svc_pkg::out_word_t result
);
  import svc_pkg::*;

  `SVC_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(result))
  `SVC_ASSERT_NOW(a_number_clean, !empty && result.number_valid, result.byte_out == 8'd0 && !result.last_byte)
  `SVC_ASSERT_NOW(a_no_stray_number, !empty && !result.number_valid, result.number_out == 32'sd0)

endmodule

bind signed_varint_codec svc_checker u_svc_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

### bench/tb.sv
// Self-checking bench for signed_varint_codec: directed table, then random words
// in both directions under three handshake idle profiles. Needs svc_pkg.
module tb;
  import svc_pkg::*;

  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic        cfg_first;
    logic        dir;
    logic [31:0] number;
    logic [7:0]  code;
    logic        typed;
    out_word_t   want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_word_t  item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_word_t result;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  logic      row_typed = 1'b0;
  out_word_t row_want = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int words_in = 0;
  int words_out = 0;
  int stall_cycles = 0;

  logic        cur_dir = DIR_ENCODE;
  logic [31:0] acc_mag = '0;
  logic [2:0]  acc_pos = POS_FIRST;
  logic        acc_neg = 1'b0;
  logic [7:0]  enc_buf [5];
  int          enc_len;

  out_word_t due_words [$];
  out_word_t head_word;
  plan_row_t plan [$];

  signed_varint_codec dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void varint_bytes(input logic [31:0] raw);
    logic [31:0] mag;
    logic        more;
    mag = raw[31] ? -raw : raw;
    enc_buf[0] = {(raw[31] || raw == 32'd0), (mag > 32'h3F), mag[5:0]};
    enc_len = 1;
    if (mag > 32'h3F) begin
      mag = mag >> 6;
      more = 1'b1;
      while (more) begin
        more = (enc_len < 4) && (mag > 32'h7F);
        enc_buf[enc_len] = {more, mag[6:0]};
        enc_len++;
        mag = mag >> 7;
      end
    end
  endfunction

  function automatic void take_word(input in_word_t w);
    out_word_t o;
    logic      done;
    if (cur_dir == DIR_ENCODE) begin
      varint_bytes(w.number_in);
      for (int k = 0; k < enc_len; k++) begin
        o = '0;
        o.byte_out = enc_buf[k];
        o.last_byte = (k == enc_len - 1);
        due_words.push_back(o);
      end
    end else begin
      o = '0;
      if (acc_pos == POS_FIRST) begin
        acc_neg = w.byte_in[7];
        acc_mag = 32'(w.byte_in[5:0]);
        done = !w.byte_in[6];
      end else begin
        acc_mag = acc_mag | (32'(w.byte_in[6:0]) << (6 + 7 * (int'(acc_pos) - 1)));
        done = !w.byte_in[7] || (acc_pos >= POS_LAST);
      end
      if (done) begin
        o.number_out = acc_neg ? -acc_mag : acc_mag;
        o.number_valid = 1'b1;
        acc_mag = '0;
        acc_pos = POS_FIRST;
        acc_neg = 1'b0;
      end else begin
        acc_pos = acc_pos + 3'd1;
      end
      due_words.push_back(o);
    end
  endfunction

  function automatic logic [31:0] rand_number();
    logic [31:0] v;
    int          bits;
    bits = $urandom_range(32);
    v = $urandom;
    if (bits < 32) v = v & 32'((64'd1 << bits) - 64'd1);
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  function automatic void plan_encode(input logic cfg_first, input logic [31:0] number,
                                      input logic typed, input logic [7:0] b,
                                      input logic last);
    plan_row_t r;
    r = '0;
    r.cfg_first = cfg_first;
    r.dir = DIR_ENCODE;
    r.number = number;
    r.typed = typed;
    r.want.byte_out = b;
    r.want.last_byte = last;
    plan.push_back(r);
  endfunction

  function automatic void plan_decode(input logic cfg_first, input logic [7:0] code,
                                      input logic typed, input logic [31:0] num,
                                      input logic valid);
    plan_row_t r;
    r = '0;
    r.cfg_first = cfg_first;
    r.dir = DIR_DECODE;
    r.code = code;
    r.typed = typed;
    r.want.number_out = num;
    r.want.number_valid = valid;
    plan.push_back(r);
  endfunction

  task automatic flag_mismatch(input string what, input out_word_t want,
                               input out_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: want byte %h last %b num %0d valid %b, got byte %h last %b num %0d valid %b",
               what, want.byte_out, want.last_byte, want.number_out, want.number_valid,
               got.byte_out, got.last_byte, got.number_out, got.number_valid);
  endtask

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
  endtask

  task automatic set_direction(input logic d);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_dir = d;
    acc_mag = '0;
    acc_pos = POS_FIRST;
    acc_neg = 1'b0;
  endtask

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        take_word(item);
        if (row_typed) begin
          void'(due_words.pop_back());
          due_words.push_back(row_want);
        end
        words_in++;
      end
      if (pop && !empty) begin
        words_out++;
        if (due_words.size() == 0) begin
          flag_mismatch("unexpected word", '0, result);
        end else begin
          head_word = due_words.pop_front();
          if (result !== head_word) flag_mismatch("mismatch", head_word, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || cfg_we) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_word_t   w;
    logic [7:0] seq [5];
    int         n;
    int         r;
    int         sent;
    int         send_pcts [3];
    int         recv_pcts [3];
    send_pcts = '{13, 84, 0};
    recv_pcts = '{84, 13, 0};

    plan_encode(1'b1, 32'd0, 1'b1, 8'h80, 1'b1);
    plan_encode(1'b0, 32'd1, 1'b1, 8'h01, 1'b1);
    plan_encode(1'b0, -32'sd1, 1'b1, 8'h81, 1'b1);
    plan_encode(1'b0, 32'd63, 1'b1, 8'h3F, 1'b1);
    plan_encode(1'b0, -32'sd63, 1'b1, 8'hBF, 1'b1);
    plan_encode(1'b0, 32'd64, 1'b0, 8'h00, 1'b0);
    plan_encode(1'b0, 32'd8191, 1'b0, 8'h00, 1'b0);
    plan_encode(1'b0, 32'h7FFF_FFFF, 1'b0, 8'h00, 1'b0);
    plan_encode(1'b0, 32'h8000_0000, 1'b0, 8'h00, 1'b0);
    plan_encode(1'b0, 32'h8000_0001, 1'b0, 8'h00, 1'b0);
    plan_decode(1'b1, 8'h80, 1'b1, 32'd0, 1'b1);
    plan_decode(1'b0, 8'h00, 1'b1, 32'd0, 1'b1);
    plan_decode(1'b0, 8'h3F, 1'b1, 32'd63, 1'b1);
    plan_decode(1'b0, 8'hBF, 1'b1, -32'sd63, 1'b1);
    plan_decode(1'b0, 8'hC0, 1'b1, 32'd0, 1'b0);
    plan_decode(1'b0, 8'h80, 1'b1, 32'd0, 1'b0);
    plan_decode(1'b0, 8'h80, 1'b1, 32'd0, 1'b0);
    plan_decode(1'b0, 8'h80, 1'b1, 32'd0, 1'b0);
    plan_decode(1'b0, 8'h10, 1'b1, 32'h8000_0000, 1'b1);
    plan_decode(1'b0, 8'h7F, 1'b0, 32'd0, 1'b0);
    plan_decode(1'b0, 8'hFF, 1'b0, 32'd0, 1'b0);
    plan_decode(1'b0, 8'hFF, 1'b0, 32'd0, 1'b0);
    plan_decode(1'b0, 8'hFF, 1'b0, 32'd0, 1'b0);
    plan_decode(1'b0, 8'hFF, 1'b0, 32'd0, 1'b0);
    plan_decode(1'b0, 8'hC1, 1'b0, 32'd0, 1'b0);
    plan_decode(1'b1, 8'h05, 1'b1, 32'd5, 1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = send_pcts[0];
    recv_idle_pct = recv_pcts[0];
    foreach (plan[i]) begin
      if (plan[i].cfg_first) set_direction(plan[i].dir);
      w.number_in = plan[i].number;
      w.byte_in = plan[i].code;
      send_word(w, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < 3; p++) begin
      set_direction(DIR_ENCODE);
      send_idle_pct = send_pcts[p];
      recv_idle_pct = recv_pcts[p];
      repeat (50) begin
        w.number_in = rand_number();
        w.byte_in = 8'($urandom_range(255));
        send_word(w, 1'b0, '0);
      end
      set_direction(DIR_DECODE);
      sent = 0;
      while (sent < 55) begin
        r = $urandom_range(9);
        if (r < 7) begin
          varint_bytes(rand_number());
          n = enc_len;
          for (int k = 0; k < n; k++) seq[k] = enc_buf[k];
        end else if (r == 7) begin
          n = 5;
          for (int k = 0; k < n; k++) seq[k] = 8'($urandom_range(255)) | 8'h80;
          seq[0] = seq[0] | 8'h40;
        end else begin
          n = 1;
          seq[0] = 8'($urandom_range(255));
        end
        for (int k = 0; k < n; k++) begin
          w.byte_in = seq[k];
          w.number_in = $urandom;
          send_word(w, 1'b0, '0);
          sent++;
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("sent %0d words in both directions under three idle profiles", words_in);
    $display("checked %0d result words, %0d mismatches", words_out, mismatches);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
